// ===== rtl/core/periodic_multi_entry_scheduler_core_macros.svh =====
// Assertion macros for the periodic multi-entry scheduler core.
// Used by the top level; needs aclk and aresetn in scope.
`ifndef PERIODIC_MULTI_ENTRY_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_MULTI_ENTRY_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define PMES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pmes_pkg.sv =====
// Shared types and constants for the periodic multi-entry scheduler.
// No dependencies.
package pmes_pkg;

    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int MASK_W     = 6;
    localparam int OUT_IDX_W  = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic                  CMD_RESTART     = 1'b1;
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE_MASK = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_BASE = 3'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_NOMINAL_MS = 16'd1000;
    localparam logic [TIME_W-1:0]   TIME_MAX          = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              restart;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic busy;
        logic walking;
    } back_status_t;

endpackage

// ===== rtl/core/pmes_front.sv =====
// Front end: accepts input beats, classifies tick/restart, queues them.
// Depends on pmes_pkg.
module pmes_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [pmes_pkg::TIME_W-1:0]  s_now_ms,
    output logic                         q_valid,
    output pmes_pkg::item_t              q_item,
    input  logic                         q_pop
);

    pmes_pkg::item_t                   mem_reg [pmes_pkg::Q_DEPTH];
    logic [pmes_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [pmes_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [pmes_pkg::Q_CNT_W-1:0]      count_reg, count_next;
    logic                              push;
    pmes_pkg::item_t                   in_item;

    assign s_ready = (count_reg != pmes_pkg::Q_CNT_W'(pmes_pkg::Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        in_item.restart = (s_cmd == pmes_pkg::CMD_RESTART);
        in_item.now_ms  = s_now_ms;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/pmes_back.sv =====
// Back end: pops queued items, clears or walks the due-time table,
// drives the registered result beat. Depends on pmes_pkg.
module pmes_back #(
    parameter int NUM_ENTRIES = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  pmes_pkg::item_t                   q_item,
    output logic                              q_pop,
    input  logic [NUM_ENTRIES-1:0]            enable_mask,
    input  logic [pmes_pkg::PERIOD_W-1:0]     period [NUM_ENTRIES],
    output pmes_pkg::back_status_t            status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pmes_pkg::OUT_IDX_W-1:0]    m_entry_index,
    output logic [pmes_pkg::TIME_W-1:0]       m_fired_due_time,
    output logic                              m_last_of_run
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                           state_reg, state_next;
    logic [NUM_ENTRIES-1:0]         fire_reg, fire_next;
    logic [pmes_pkg::TIME_W-1:0]    now_reg;
    logic [pmes_pkg::TIME_W-1:0]    due_reg [NUM_ENTRIES];

    logic                           m_valid_reg;
    logic [pmes_pkg::OUT_IDX_W-1:0] m_index_reg;
    logic [pmes_pkg::TIME_W-1:0]    m_due_reg;
    logic                           m_last_reg;

    logic [NUM_ENTRIES-1:0]         hit;
    logic [IDX_W-1:0]               cur_idx;
    logic [NUM_ENTRIES-1:0]         rest;
    logic                           out_free;
    logic                           emit;
    logic                           do_restart;
    logic                           do_tick;
    logic [pmes_pkg::TIME_W-1:0]    cur_due;
    logic [pmes_pkg::PERIOD_W-1:0]  cur_period;
    logic [pmes_pkg::TIME_W:0]      sum_due;
    logic [pmes_pkg::TIME_W:0]      sum_now;
    logic [pmes_pkg::TIME_W-1:0]    sat_due;
    logic [pmes_pkg::TIME_W-1:0]    sat_now;
    logic [pmes_pkg::TIME_W-1:0]    due_new;

    assign out_free   = !m_valid_reg || m_ready;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign do_restart = q_pop && q_item.restart;
    assign do_tick    = q_pop && !q_item.restart;
    assign emit       = (state_reg == ST_WALK) && out_free;

    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            hit[i] = enable_mask[i] && !(q_item.now_ms < due_reg[i]);
        end
    end

    always_comb begin
        cur_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (fire_reg[i]) begin
                cur_idx = IDX_W'(i);
            end
        end
        rest = fire_reg;
        rest[cur_idx] = 1'b0;
    end

    // advance with saturation; zero period means default
    always_comb begin
        cur_due    = due_reg[cur_idx];
        cur_period = (period[cur_idx] == '0) ? pmes_pkg::PERIOD_NOMINAL_MS : period[cur_idx];
        sum_due    = {1'b0, cur_due} + {17'd0, cur_period};
        sum_now    = {1'b0, now_reg} + {17'd0, cur_period};
        sat_due    = sum_due[pmes_pkg::TIME_W] ? pmes_pkg::TIME_MAX
                                               : sum_due[pmes_pkg::TIME_W-1:0];
        sat_now    = sum_now[pmes_pkg::TIME_W] ? pmes_pkg::TIME_MAX
                                               : sum_now[pmes_pkg::TIME_W-1:0];
        due_new    = (sat_due > now_reg) ? sat_due : sat_now;
    end

    always_comb begin
        state_next = state_reg;
        fire_next  = fire_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (do_tick && (hit != '0)) begin
                    fire_next  = hit;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (emit) begin
                    fire_next = rest;
                    if (rest == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fire_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                due_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            fire_reg  <= fire_next;
            if (emit) begin
                m_valid_reg      <= 1'b1;
                due_reg[cur_idx] <= due_new;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (do_restart) begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    due_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_tick) begin
            now_reg <= q_item.now_ms;
        end
        if (emit) begin
            m_index_reg <= pmes_pkg::OUT_IDX_W'(cur_idx);
            m_due_reg   <= cur_due;
            m_last_reg  <= (rest == '0);
        end
    end

    assign status.busy       = (state_reg != ST_IDLE);
    assign status.walking    = (state_reg == ST_WALK) && (fire_reg != '0);
    assign m_valid          = m_valid_reg;
    assign m_entry_index    = m_index_reg;
    assign m_fired_due_time = m_due_reg;
    assign m_last_of_run    = m_last_reg;

endmodule

// ===== rtl/core/periodic_multi_entry_scheduler_core.sv =====
// Periodic multi-entry scheduler core: config registers, front queue, back walker.
// Depends on pmes_pkg, pmes_front, pmes_back and the core macros header.
//
// Usage:
// Input channel (s_*): one beat per tick (s_cmd = 0, s_now_ms = current ms)
// or restart (s_cmd = 1, clears all due times, no result).
// Result channel (m_*): one beat per entry that fired, in index order,
// carrying the index and the due time it held; m_last_of_run marks the
// final beat of a tick. A tick where nothing fires gives no beat.
// Config port: cfg_we writes cfg_wdata to register cfg_addr (0 = enable
// mask, 1..6 = entry periods) at once; write only while idle.
// Flow: a tick is popped and compared against all entries, then each fired
// entry is walked; a restart is only popped. The entry walk, one entry per
// cycle through a shared add/compare unit while the output register is free,
// limits the tick rate. m_valid rises once an accepted beat has passed the
// queue, the fire mask and walk state, and the output register.
// A 2-deep queue lets new beats in while the walker works.
// Reset: aresetn (synchronous, low) clears due times, mask to 0, periods
// to 1000 ms, and empties the queue and output register.
// Stall: m_ready held low freezes the walker; the queue then fills and
// s_ready drops.
`include "periodic_multi_entry_scheduler_core_macros.svh"

module periodic_multi_entry_scheduler_core #(
    parameter int NUM_ENTRIES = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [pmes_pkg::TIME_W-1:0]       s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pmes_pkg::OUT_IDX_W-1:0]    m_entry_index,
    output logic [pmes_pkg::TIME_W-1:0]       m_fired_due_time,
    output logic                              m_last_of_run,
    input  logic                              cfg_we,
    input  logic [pmes_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pmes_pkg::PERIOD_W-1:0]     cfg_wdata
);

    logic [pmes_pkg::MASK_W-1:0]   enable_mask_reg;
    logic [pmes_pkg::PERIOD_W-1:0] period_reg [NUM_ENTRIES];

    logic                          q_valid;
    pmes_pkg::item_t               q_item;
    logic                          q_pop;
    pmes_pkg::back_status_t        back_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                period_reg[i] <= pmes_pkg::PERIOD_NOMINAL_MS;
            end
        end else if (cfg_we) begin
            if (cfg_addr == pmes_pkg::REG_ENABLE_MASK) begin
                enable_mask_reg <= cfg_wdata[pmes_pkg::MASK_W-1:0];
            end
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (cfg_addr == pmes_pkg::REG_PERIOD_BASE + pmes_pkg::CFG_ADDR_W'(i)) begin
                    period_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    pmes_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_now_ms (s_now_ms),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pmes_back #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .enable_mask      (enable_mask_reg[NUM_ENTRIES-1:0]),
        .period           (period_reg),
        .status           (back_status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_entry_index    (m_entry_index),
        .m_fired_due_time (m_fired_due_time),
        .m_last_of_run    (m_last_of_run)
    );

    `PMES_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid, "queue popped while empty")
    `PMES_ASSERT_NOW(a_no_pop_walking, back_status.busy, !q_pop, "queue popped during walk")
    `PMES_ASSERT_NEXT(a_restart_idle, q_pop && q_item.restart, !back_status.busy, "restart walked")
    `PMES_ASSERT_NOW(a_walk_has_work, back_status.busy, back_status.walking, "walk with empty fire mask")

endmodule
